### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

### rtl/rmac_pkg.sv
// ----------------------------------------------------------------------------
// rmac_pkg
// Shared types and constants of the register map access checker.
// ----------------------------------------------------------------------------
`default_nettype none
package rmac_pkg;
  localparam int RangeSlotsDef = 8;
  localparam int DescSlotsDef  = 16;
  localparam int StatW = 32;

  typedef enum logic [1:0] {
    OP_READ = 2'd0, OP_WRITE = 2'd1, OP_ADD_RANGE = 2'd2, OP_ADD_DESC = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_RD_DENIED = 3'd1, ST_WR_DENIED = 3'd2, ST_UNMAPPED = 3'd3,
    ST_NO_DESC = 3'd4, ST_REJECTED = 3'd5, ST_FULL = 3'd6
  } status_t;

  localparam logic [1:0] MODE_READ  = 2'h1;
  localparam logic [1:0] MODE_WRITE = 2'h2;
  localparam logic [1:0] FLAG_RD_EXT = 2'h1;
  localparam logic [1:0] FLAG_WR_EXT = 2'h2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_EXEC = 3'b010, S_OUT = 3'b100
  } state_t;

  function automatic logic [StatW-1:0] sat_inc(input logic [StatW-1:0] c);
    sat_inc = (c == '1) ? c : c + StatW'(1);
  endfunction
endpackage
`default_nettype wire

### rtl/register_map_access_checker_unit.sv
// ----------------------------------------------------------------------------
// register_map_access_checker_unit
// Range-checked register map with descriptor store and statistics.
// ----------------------------------------------------------------------------
// One item at a time: a beat is taken in IDLE, where the descriptor keys
// are matched on the incoming address and the descriptor value memory
// starts its registered read; in EXEC the range table is matched and the
// result register is loaded. The result beat is offered in OUT, and the
// next input beat is only taken back in IDLE once the result is taken,
// so an output that is held off holds off the input too. The range tables
// and descriptor keys sit in flip-flops for the parallel match; the
// descriptor values live in a one-port synchronous memory, read on
// acceptance and written back in EXEC. No clearing pass: entries are only
// consulted below the fill count.
`default_nettype none
`include "assert_macros.svh"
module register_map_access_checker_unit #(
  parameter int RANGE_SLOTS      = rmac_pkg::RangeSlotsDef,
  parameter int DESCRIPTOR_SLOTS = rmac_pkg::DescSlotsDef
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data,      // value store enable
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [1:0] opcode, [33:2] address, [65:34] value, [97:66] range_end,
  // [99:98] access_mode, [131:100] allowed_mask, [132] read_external,
  // [133] write_external, [165:134] external_data, [167:166] zero
  input  wire logic [167:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [31:0] read_data, [34:32] status, [35] ext_write_strobe,
  // [67:36] ext_write_data, [99:68] read_count, [131:100] write_count,
  // [163:132] read_error_count, [195:164] write_error_count,
  // [227:196] violation_count, [231:228] zero
  output logic [231:0]      m_tdata
);
  import rmac_pkg::*;

  localparam int RIW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
  localparam int RCW = $clog2(RANGE_SLOTS + 1);
  localparam int DIW = (DESCRIPTOR_SLOTS > 1) ? $clog2(DESCRIPTOR_SLOTS) : 1;
  localparam int DCW = $clog2(DESCRIPTOR_SLOTS + 1);

  state_t state;
  logic store_en;

  // range and descriptor key tables
  logic [31:0] rng_start [RANGE_SLOTS];
  logic [31:0] rng_end   [RANGE_SLOTS];
  logic [1:0]  rng_mode  [RANGE_SLOTS];
  logic [RCW-1:0] range_count;
  logic [31:0] desc_addr [DESCRIPTOR_SLOTS];
  logic [31:0] desc_mask [DESCRIPTOR_SLOTS];
  logic [1:0]  desc_flag [DESCRIPTOR_SLOTS];
  logic [DCW-1:0] desc_count;
  logic [31:0] desc_value_mem [DESCRIPTOR_SLOTS];
  logic [31:0] mem_rdata;

  logic [StatW-1:0] cnt_rd, cnt_wr, cnt_rd_err, cnt_wr_err, cnt_viol;

  // latched item
  op_t         op;
  logic [31:0] addr, val, rend, mask, xdata;
  logic [1:0]  mode;
  logic        rext, wext;

  // descriptor match on the incoming address; slot is registered
  logic [DIW-1:0] in_slot, slot;
  logic           in_hit, hit;
  always_comb begin
    in_hit = 1'b0;
    in_slot = '0;
    for (int i = DESCRIPTOR_SLOTS - 1; i >= 0; i--) begin
      if (DCW'(i) < desc_count && desc_addr[i] == s_tdata[33:2]) begin
        in_hit = 1'b1;
        in_slot = DIW'(i);
      end
    end
  end

  // newest covering range
  logic       r_hit;
  logic [1:0] r_mode;
  always_comb begin
    r_hit = 1'b0;
    r_mode = '0;
    for (int i = 0; i < RANGE_SLOTS; i++) begin
      if (RCW'(i) < range_count && addr >= rng_start[i] && addr <= rng_end[i]) begin
        r_hit = 1'b1;
        r_mode = rng_mode[i];
      end
    end
  end

  // resolve the item
  logic [31:0] rdata_n, sdata_n;
  status_t     status_n;
  logic        strobe_n, mem_we, inc_rd, inc_wr, inc_rde, inc_wre, inc_v;
  logic        add_rng, add_desc;
  always_comb begin
    rdata_n = '0; sdata_n = '0; status_n = ST_OK; strobe_n = 1'b0; mem_we = 1'b0;
    inc_rd = 1'b0; inc_wr = 1'b0; inc_rde = 1'b0; inc_wre = 1'b0; inc_v = 1'b0;
    add_rng = 1'b0; add_desc = 1'b0;
    case (op)
      OP_READ, OP_WRITE: begin
        inc_rd = (op == OP_READ);
        inc_wr = (op == OP_WRITE);
        if (!r_hit) begin
          status_n = ST_UNMAPPED; inc_v = 1'b1;
        end else if (op == OP_READ && (r_mode & MODE_READ) == '0) begin
          status_n = ST_RD_DENIED; inc_rde = 1'b1;
        end else if (op == OP_WRITE && (r_mode & MODE_WRITE) == '0) begin
          status_n = ST_WR_DENIED; inc_wre = 1'b1;
        end else if (!hit) begin
          status_n = ST_NO_DESC;
        end else if (op == OP_READ) begin
          if ((desc_flag[slot] & FLAG_RD_EXT) != '0) rdata_n = xdata;
          else if (store_en) rdata_n = mem_rdata;
        end else if ((val & ~desc_mask[slot]) != '0) begin
          status_n = ST_REJECTED; inc_wre = 1'b1;
        end else begin
          if ((desc_flag[slot] & FLAG_WR_EXT) != '0) begin
            strobe_n = 1'b1; sdata_n = val;
          end
          mem_we = store_en;
        end
      end
      OP_ADD_RANGE: begin
        if (range_count >= RCW'(RANGE_SLOTS)) status_n = ST_FULL;
        else add_rng = 1'b1;
      end
      default: begin
        if (desc_count >= DCW'(DESCRIPTOR_SLOTS)) status_n = ST_FULL;
        else add_desc = 1'b1;
      end
    endcase
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);

  // control, counters and tables
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      store_en <= 1'b1;
      range_count <= '0;
      desc_count <= '0;
      cnt_rd <= '0; cnt_wr <= '0; cnt_rd_err <= '0; cnt_wr_err <= '0; cnt_viol <= '0;
    end else begin
      if (cfg_valid && cfg_ready) store_en <= cfg_data;
      case (state)
        S_IDLE: if (s_tvalid) state <= S_EXEC;
        S_EXEC: begin
          state <= S_OUT;
          if (inc_rd) cnt_rd <= sat_inc(cnt_rd);
          if (inc_wr) cnt_wr <= sat_inc(cnt_wr);
          if (inc_rde) cnt_rd_err <= sat_inc(cnt_rd_err);
          if (inc_wre) cnt_wr_err <= sat_inc(cnt_wr_err);
          if (inc_v) cnt_viol <= sat_inc(cnt_viol);
          if (add_rng) range_count <= range_count + RCW'(1);
          if (add_desc) desc_count <= desc_count + DCW'(1);
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // latch the item and the match
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op <= op_t'(s_tdata[1:0]);
      addr <= s_tdata[33:2];   val <= s_tdata[65:34];
      rend <= s_tdata[97:66];  mode <= s_tdata[99:98];
      mask <= s_tdata[131:100]; rext <= s_tdata[132];
      wext <= s_tdata[133];    xdata <= s_tdata[165:134];
      hit <= in_hit;           slot <= in_slot;
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (state == S_EXEC && add_rng) begin
      rng_start[range_count[RIW-1:0]] <= addr;
      rng_end[range_count[RIW-1:0]]   <= rend;
      rng_mode[range_count[RIW-1:0]]  <= mode;
    end
    if (state == S_EXEC && add_desc) begin
      desc_addr[desc_count[DIW-1:0]] <= addr;
      desc_mask[desc_count[DIW-1:0]] <= mask;
      desc_flag[desc_count[DIW-1:0]] <= {wext, rext};
    end
  end

  // value memory: read on acceptance, write in the execute cycle
  always_ff @(posedge clk) begin
    if (state == S_EXEC && add_desc) desc_value_mem[desc_count[DIW-1:0]] <= val;
    else if (state == S_EXEC && mem_we) desc_value_mem[slot] <= val;
    if (s_tvalid && s_tready) mem_rdata <= desc_value_mem[in_slot];
  end

  // result register; counters follow the live registers
  logic [31:0] rdata_q, sdata_q;
  status_t     status_q;
  logic        strobe_q;
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      rdata_q <= rdata_n; sdata_q <= sdata_n; status_q <= status_n; strobe_q <= strobe_n;
    end
  end
  assign m_tdata = {4'b0, cnt_viol, cnt_wr_err, cnt_rd_err, cnt_wr, cnt_rd,
                    sdata_q, strobe_q, status_q, rdata_q};

  // fill counts stay within the tables
  logic fill_ok;
  assign fill_ok = range_count <= RCW'(RANGE_SLOTS) && desc_count <= DCW'(DESCRIPTOR_SLOTS);

  `ASSERT_CLK(a_strobe_ok, clk, rst, !(m_tvalid && strobe_q) || status_q == ST_OK, "strobe")
  `ASSERT_CLK(a_rd_clean, clk, rst, !(m_tvalid && status_q != ST_OK) || rdata_q == '0, "data")
  `ASSERT_CLK(a_cnt_bound, clk, rst, fill_ok, "count overflow")
endmodule
`default_nettype wire
